[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files of the array block; bira_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define ASSERT_PROP(LBL, CLK, RSTN, PROP, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);

// Same-cycle implication.
`define ASSERT_IMPL(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    `ASSERT_PROP(LBL, CLK, RSTN, (ANTE) |-> (CONS), MSG)

// Next-cycle implication.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    `ASSERT_PROP(LBL, CLK, RSTN, (ANTE) |=> (CONS), MSG)

`endif

[rtl/core/bira_pkg.sv]
// Shared constants, codes and types of the bounded insert/remove array.
package bira_pkg;

    localparam int DEPTH   = 64;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 7;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int GRP     = 8;
    localparam int NGRP    = DEPTH / GRP;
    localparam int GIDX_W  = $clog2(GRP);
    localparam int GSEL_W  = IDX_W - GIDX_W;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_PUSH   = 3'd2,
        CMD_POP    = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_REMOVE = 3'd5,
        CMD_FIND   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_e;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_INDEX = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_UNDER = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_REDUCE = 2'd2,
        ST_FINISH = 2'd3
    } state_e;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_e;

    typedef struct packed {
        cell_op_e            op;
        logic [IDX_W-1:0]    pos;
        logic                rd_en;
        logic [IDX_W-1:0]    rd_pos;
        logic                find_en;
        logic [CNT_W-1:0]    count;
        logic [WORD_W-1:0]   value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    found_index;
        logic [WORD_W-1:0]   data;
    } red_res_t;

endpackage

[rtl/core/bira_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface bira_in_if;
    logic                             valid;
    logic                             ready;
    logic [bira_pkg::CMD_W-1:0]       cmd;
    logic [bira_pkg::CNT_W-1:0]       position;
    logic [bira_pkg::WORD_W-1:0]      value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface bira_out_if;
    logic                             valid;
    logic                             ready;
    logic [bira_pkg::STAT_W-1:0]      status;
    logic [bira_pkg::WORD_W-1:0]      data;
    logic                             found;
    logic [bira_pkg::IDX_W-1:0]       found_index;
    logic [bira_pkg::CNT_W-1:0]       count;
    logic                             empty_res;
    logic                             full_res;

    modport source (output valid, output status, output data, output found,
                    output found_index, output count, output empty_res,
                    output full_res, input ready);
    modport sink   (input valid, input status, input data, input found,
                    input found_index, input count, input empty_res,
                    input full_res, output ready);
endinterface

[rtl/core/bira_cell.sv]
// One storage cell of the array: holds a word, shifts with its neighbours, matches and selects.
module bira_cell (
    input  logic                            clk,
    input  bira_pkg::cell_ctrl_t            ctrl,
    input  logic [bira_pkg::IDX_W-1:0]      idx,
    input  logic [bira_pkg::WORD_W-1:0]     left_word,
    input  logic [bira_pkg::WORD_W-1:0]     right_word,
    output logic [bira_pkg::WORD_W-1:0]     word,
    output logic [bira_pkg::WORD_W-1:0]     sel_word,
    output logic                            hit
);

    logic [bira_pkg::WORD_W-1:0] word_reg;
    logic [bira_pkg::WORD_W-1:0] word_next;
    logic [bira_pkg::WORD_W-1:0] sel_reg;
    logic [bira_pkg::WORD_W-1:0] sel_next;
    logic                        hit_reg;
    logic                        hit_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            bira_pkg::CELL_WRITE:
            begin
                if (idx == ctrl.pos)
                begin
                    word_next = ctrl.value;
                end
            end
            bira_pkg::CELL_INSERT:
            begin
                if (idx == ctrl.pos)
                begin
                    word_next = ctrl.value;
                end
                else if (idx > ctrl.pos)
                begin
                    word_next = left_word;
                end
            end
            bira_pkg::CELL_REMOVE:
            begin
                if (idx >= ctrl.pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase

        // read the old contents, ahead of any shift in the same cycle
        sel_next = (ctrl.rd_en && (idx == ctrl.rd_pos)) ? word_reg : '0;
        hit_next = ctrl.find_en && ({1'b0, idx} < ctrl.count) && (word_reg == ctrl.value);
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        sel_reg  <= sel_next;
        hit_reg  <= hit_next;
    end

    assign word     = word_reg;
    assign sel_word = sel_reg;
    assign hit      = hit_reg;

endmodule

[rtl/core/bira_reduce.sv]
// Two-level reduction of cell match flags and selected words: group registers, then a final pick.
module bira_reduce (
    input  logic                            clk,
    input  logic                            load,
    input  logic [bira_pkg::DEPTH-1:0]      hit_bus,
    input  logic [bira_pkg::WORD_W-1:0]     sel_bus [bira_pkg::DEPTH],
    output bira_pkg::red_res_t              res
);

    logic [bira_pkg::NGRP-1:0]   ghit_reg;
    logic [bira_pkg::NGRP-1:0]   ghit_next;
    logic [bira_pkg::GIDX_W-1:0] gidx_reg  [bira_pkg::NGRP];
    logic [bira_pkg::GIDX_W-1:0] gidx_next [bira_pkg::NGRP];
    logic [bira_pkg::WORD_W-1:0] gword_reg  [bira_pkg::NGRP];
    logic [bira_pkg::WORD_W-1:0] gword_next [bira_pkg::NGRP];
    logic [bira_pkg::GSEL_W-1:0] gsel;
    logic [bira_pkg::WORD_W-1:0] data_or;

    // per group: any hit, lowest hit within the group, OR of selected words
    always_comb
    begin
        for (int g = 0; g < bira_pkg::NGRP; g++)
        begin
            ghit_next[g]  = 1'b0;
            gidx_next[g]  = '0;
            gword_next[g] = '0;
            for (int j = bira_pkg::GRP - 1; j >= 0; j--)
            begin
                if (hit_bus[g * bira_pkg::GRP + j])
                begin
                    ghit_next[g] = 1'b1;
                    gidx_next[g] = bira_pkg::GIDX_W'(j);
                end
                gword_next[g] = gword_next[g] | sel_bus[g * bira_pkg::GRP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ghit_reg <= ghit_next;
            for (int g = 0; g < bira_pkg::NGRP; g++)
            begin
                gidx_reg[g]  <= gidx_next[g];
                gword_reg[g] <= gword_next[g];
            end
        end
    end

    // pick the lowest group with a hit
    always_comb
    begin
        gsel    = '0;
        data_or = '0;
        for (int g = bira_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (ghit_reg[g])
            begin
                gsel = bira_pkg::GSEL_W'(g);
            end
            data_or = data_or | gword_reg[g];
        end
        res.found       = |ghit_reg;
        res.found_index = (|ghit_reg) ? {gsel, gidx_reg[gsel]} : '0;
        res.data        = data_or;
    end

endmodule

[rtl/core/bira_ctrl.sv]
// Command sequencer: capacity register, entry count, status checks, cell control and result register.
`include "assert_macros.svh"

module bira_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bira_pkg::CNT_W-1:0]      cfg_wdata,
    bira_in_if.sink                         req,
    bira_out_if.source                      rsp,
    output bira_pkg::cell_ctrl_t            cell_ctrl,
    output logic                            red_load,
    input  bira_pkg::red_res_t              red_res
);

    bira_pkg::state_e               state_reg;
    bira_pkg::state_e               state_next;
    logic [bira_pkg::CNT_W-1:0]     capacity_reg;
    logic [bira_pkg::CNT_W-1:0]     count_reg;
    logic [bira_pkg::CNT_W-1:0]     count_next;
    bira_pkg::status_e              status_reg;
    bira_pkg::status_e              status_next;
    bira_pkg::cmd_e                 cmd_reg;
    logic [bira_pkg::CNT_W-1:0]     pos_reg;
    logic [bira_pkg::WORD_W-1:0]    value_reg;
    logic [bira_pkg::CNT_W-1:0]     cap_eff;
    logic [bira_pkg::CNT_W-1:0]     count_dec;
    bira_pkg::cell_ctrl_t           cc_calc;
    logic                           out_load;
    logic                           out_valid_reg;
    bira_pkg::status_e              out_status_reg;
    logic [bira_pkg::WORD_W-1:0]    out_data_reg;
    logic                           out_found_reg;
    logic [bira_pkg::IDX_W-1:0]     out_fidx_reg;
    logic [bira_pkg::CNT_W-1:0]     out_count_reg;
    logic                           out_empty_reg;
    logic                           out_full_reg;

    assign cap_eff   = (capacity_reg > bira_pkg::DEPTH_CNT) ? bira_pkg::DEPTH_CNT : capacity_reg;
    assign count_dec = count_reg - 1'b1;

    // decode the held command against the current count
    always_comb
    begin
        status_next     = bira_pkg::STAT_OK;
        count_next      = count_reg;
        cc_calc.op      = bira_pkg::CELL_HOLD;
        cc_calc.pos     = pos_reg[bira_pkg::IDX_W-1:0];
        cc_calc.rd_en   = 1'b0;
        cc_calc.rd_pos  = pos_reg[bira_pkg::IDX_W-1:0];
        cc_calc.find_en = 1'b0;
        cc_calc.count   = count_reg;
        cc_calc.value   = value_reg;
        case (cmd_reg)
            bira_pkg::CMD_GET:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = bira_pkg::STAT_INDEX;
                end
                else
                begin
                    cc_calc.rd_en = 1'b1;
                end
            end
            bira_pkg::CMD_SET:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = bira_pkg::STAT_INDEX;
                end
                else
                begin
                    cc_calc.op = bira_pkg::CELL_WRITE;
                end
            end
            bira_pkg::CMD_PUSH:
            begin
                if (count_reg >= cap_eff)
                begin
                    status_next = bira_pkg::STAT_OVER;
                end
                else
                begin
                    cc_calc.op  = bira_pkg::CELL_WRITE;
                    cc_calc.pos = count_reg[bira_pkg::IDX_W-1:0];
                    count_next  = count_reg + 1'b1;
                end
            end
            bira_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = bira_pkg::STAT_UNDER;
                end
                else
                begin
                    cc_calc.rd_en  = 1'b1;
                    cc_calc.rd_pos = count_dec[bira_pkg::IDX_W-1:0];
                    count_next     = count_dec;
                end
            end
            bira_pkg::CMD_INSERT:
            begin
                // index is checked before room
                if (pos_reg > count_reg)
                begin
                    status_next = bira_pkg::STAT_INDEX;
                end
                else if (count_reg >= cap_eff)
                begin
                    status_next = bira_pkg::STAT_OVER;
                end
                else
                begin
                    cc_calc.op = bira_pkg::CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            bira_pkg::CMD_REMOVE:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = bira_pkg::STAT_INDEX;
                end
                else
                begin
                    cc_calc.rd_en = 1'b1;
                    cc_calc.op    = bira_pkg::CELL_REMOVE;
                    count_next    = count_dec;
                end
            end
            bira_pkg::CMD_FIND:
            begin
                cc_calc.find_en = 1'b1;
            end
            bira_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = bira_pkg::STAT_OK;
            end
        endcase
    end

    // sequencer and handshake control
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        red_load   = 1'b0;
        out_load   = 1'b0;
        cell_ctrl  = cc_calc;
        if (state_reg != bira_pkg::ST_EXEC)
        begin
            cell_ctrl.op      = bira_pkg::CELL_HOLD;
            cell_ctrl.rd_en   = 1'b0;
            cell_ctrl.find_en = 1'b0;
        end
        case (state_reg)
            bira_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = bira_pkg::ST_EXEC;
                end
            end
            bira_pkg::ST_EXEC:
            begin
                state_next = bira_pkg::ST_REDUCE;
            end
            bira_pkg::ST_REDUCE:
            begin
                red_load   = 1'b1;
                state_next = bira_pkg::ST_FINISH;
            end
            bira_pkg::ST_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = bira_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bira_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bira_pkg::ST_IDLE;
            capacity_reg  <= bira_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (state_reg == bira_pkg::ST_EXEC)
            begin
                count_reg <= count_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg   <= bira_pkg::cmd_e'(req.cmd);
            pos_reg   <= req.position;
            value_reg <= req.value;
        end
        if (state_reg == bira_pkg::ST_EXEC)
        begin
            status_reg <= status_next;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= red_res.data;
            out_found_reg  <= red_res.found;
            out_fidx_reg   <= red_res.found_index;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
            out_full_reg   <= (count_reg >= cap_eff);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data        = out_data_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.found_index = out_fidx_reg;
    assign rsp.count       = out_count_reg;
    assign rsp.empty_res   = out_empty_reg;
    assign rsp.full_res    = out_full_reg;

    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= bira_pkg::DEPTH_CNT, "entry count above depth")
    `ASSERT_NEXT(a_fail_keeps_count, clk, rst_n,
        state_reg == bira_pkg::ST_EXEC && status_next != bira_pkg::STAT_OK,
        $stable(count_reg), "failed command changed the count")
    `ASSERT_NEXT(a_finish_waits, clk, rst_n,
        state_reg == bira_pkg::ST_FINISH && !out_load,
        state_reg == bira_pkg::ST_FINISH && out_valid_reg, "result dropped while stalled")

endmodule

[rtl/core/bounded_insert_remove_array.sv]
// Top level of the bounded insert/remove array: sequencer, row of cells and reduction tree.
//
// Usage
//   req : command word (cmd, position, value), accepted when valid and ready are high.
//   rsp : result word (status, data, found, found_index, count, empty_res, full_res).
//   cfg_we / cfg_wdata : write the capacity register; write only while the block is idle.
// Sequence
//   Each command steps through accept, update and read the cell row, register the
//   per-group reduction, pick the final group into the result register. The sequencer
//   steps through those stages; insert, remove and find shift or match in all cells at
//   once, so every command costs the same. A new word is accepted only after the
//   previous command's result has been loaded into the result register.
// Stalls
//   The result register parts the two sides: the next command is taken and worked while
//   the previous result waits. If that result is still not taken when the next one is
//   ready, the sequencer holds in its final stage and req.ready stays low.
// Reset
//   Count clears, capacity returns to 64 and no result is pending. Stored words are not
//   cleared; only entries below the count are ever read.
module bounded_insert_remove_array (
    input  logic                            clk,
    input  logic                            rst_n,
    bira_in_if.sink                         req,
    bira_out_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [bira_pkg::CNT_W-1:0]      cfg_wdata
);

    bira_pkg::cell_ctrl_t           cell_ctrl;
    logic                           red_load;
    bira_pkg::red_res_t             red_res;
    logic [bira_pkg::WORD_W-1:0]    word_bus [bira_pkg::DEPTH];
    logic [bira_pkg::WORD_W-1:0]    sel_bus  [bira_pkg::DEPTH];
    logic [bira_pkg::DEPTH-1:0]     hit_bus;

    // sequencer: decode, count, status and the result register
    bira_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cell_ctrl (cell_ctrl),
        .red_load  (red_load),
        .red_res   (red_res)
    );

    // row of cells; insert takes from the left neighbour, remove from the right
    for (genvar i = 0; i < bira_pkg::DEPTH; i++)
    begin : g_cell
        logic [bira_pkg::WORD_W-1:0] left_word;
        logic [bira_pkg::WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_inner_l
            assign left_word = word_bus[i-1];
        end

        // the last cell keeps its own word on remove
        if (i == bira_pkg::DEPTH - 1)
        begin : g_last
            assign right_word = word_bus[i];
        end
        else
        begin : g_inner_r
            assign right_word = word_bus[i+1];
        end

        bira_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .idx        (bira_pkg::IDX_W'(i)),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (word_bus[i]),
            .sel_word   (sel_bus[i]),
            .hit        (hit_bus[i])
        );
    end

    // match flags and read words reduced in two levels: group registers, then a final pick
    bira_reduce u_reduce (
        .clk     (clk),
        .load    (red_load),
        .hit_bus (hit_bus),
        .sel_bus (sel_bus),
        .res     (red_res)
    );

endmodule

[dv/bounded_insert_remove_array_tb.sv]
// Self-checking testbench for the bounded insert/remove array: directed table, then random traffic.
`timescale 1ns / 1ps

module bounded_insert_remove_array_tb;
    import bira_pkg::*;

    // Cycles with no word accepted on either side before the run is abandoned.
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_WORDS  = 212;
    localparam int N_PHASES     = 8;

    // One result word as the checker sees it.
    typedef struct packed {
        status_e             status;
        logic [WORD_W-1:0]   data;
        logic                found;
        logic [IDX_W-1:0]    found_index;
        logic [CNT_W-1:0]    count;
        logic                empty_res;
        logic                full_res;
    } outcome_t;

    // Row of the directed table: either a capacity write or a command word,
    // the latter with an optional typed-in result.
    typedef struct {
        bit                  is_cfg;
        cmd_e                cmd;
        logic [CNT_W-1:0]    position;
        logic [WORD_W-1:0]   value;
        bit                  typed;
        outcome_t            want;
    } dir_row_t;

    // Traffic shapes for the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BLEND
    } mix_e;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;

    bira_in_if  req_if ();
    bira_out_if rsp_if ();

    bounded_insert_remove_array dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the array: stored words, count and capacity register.
    logic [WORD_W-1:0]   shadow_words [DEPTH];
    int                  shadow_count;
    logic [CNT_W-1:0]    shadow_cap;

    // Results still owed by the block, oldest first.
    outcome_t            pending_outcomes [$];
    dir_row_t            stim_rows [$];

    int                  error_count;
    int                  quiet_cycles;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  results_seen;
    int                  cfg_writes;
    int                  status_tally [4];
    int                  cmd_tally [8];
    mix_e                traffic_mix;
    int                  mix_left;

    // Free-running clock, 4 ns period.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Work one command on the shadow array and return the result it must give.
    function automatic outcome_t apply_to_shadow(cmd_e c, logic [CNT_W-1:0] pos,
                                                 logic [WORD_W-1:0] v);
        outcome_t o;
        int       room;
        int       i;
        o = '0;
        o.status = STAT_OK;
        // Capacity above the built depth saturates; zero means no room at all.
        room = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
        case (c)
            CMD_GET:
                if (pos >= shadow_count) o.status = STAT_INDEX;
                else o.data = shadow_words[pos];
            CMD_SET:
                if (pos >= shadow_count) o.status = STAT_INDEX;
                else shadow_words[pos] = v;
            CMD_PUSH:
                if (shadow_count >= room) o.status = STAT_OVER;
                else
                begin
                    shadow_words[shadow_count] = v;
                    shadow_count++;
                end
            CMD_POP:
                if (shadow_count == 0) o.status = STAT_UNDER;
                else
                begin
                    shadow_count--;
                    o.data = shadow_words[shadow_count];
                end
            CMD_INSERT:
                // The index is checked before room, so a bad index wins over full.
                if (pos > shadow_count) o.status = STAT_INDEX;
                else if (shadow_count >= room) o.status = STAT_OVER;
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = v;
                    shadow_count++;
                end
            CMD_REMOVE:
                if (pos >= shadow_count) o.status = STAT_INDEX;
                else
                begin
                    o.data = shadow_words[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            CMD_FIND:
                // Lowest matching index only.
                for (i = 0; i < shadow_count; i++)
                    if (!o.found && shadow_words[i] == v)
                    begin
                        o.found       = 1'b1;
                        o.found_index = i[IDX_W-1:0];
                    end
            default:
                shadow_count = 0;
        endcase
        o.count     = shadow_count[CNT_W-1:0];
        o.empty_res = (shadow_count == 0);
        o.full_res  = (shadow_count >= room);
        return o;
    endfunction

    // Table builders: a row checked against the shadow array, a row with a typed-in
    // result (data and find fields zero), and a capacity write.
    function automatic void add_checked(cmd_e c, logic [CNT_W-1:0] p, logic [WORD_W-1:0] v);
        dir_row_t r;
        r = '{is_cfg: 1'b0, cmd: c, position: p, value: v, typed: 1'b0, want: '0};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_typed(cmd_e c, logic [CNT_W-1:0] p, logic [WORD_W-1:0] v,
                                      status_e s, logic [CNT_W-1:0] cnt, logic e, logic f);
        dir_row_t r;
        outcome_t o;
        o = '0;
        o.status    = s;
        o.count     = cnt;
        o.empty_res = e;
        o.full_res  = f;
        r = '{is_cfg: 1'b0, cmd: c, position: p, value: v, typed: 1'b1, want: o};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_cfg(logic [CNT_W-1:0] cap);
        dir_row_t r;
        r = '{is_cfg: 1'b1, cmd: CMD_GET, position: '0, value: {{(WORD_W-CNT_W){1'b0}}, cap},
              typed: 1'b0, want: '0};
        stim_rows.push_back(r);
    endfunction

    // Offer one command word, with a random idle gap first, and hold it until taken.
    // Valid stays high afterwards so back-to-back words need no second assignment.
    task automatic send_word(input cmd_e c, input logic [CNT_W-1:0] p,
                             input logic [WORD_W-1:0] v, input bit typed, input outcome_t want);
        outcome_t o;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= c;
        req_if.position <= p;
        req_if.value    <= v;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        // Accepted at this edge: advance the shadow array and log what is owed.
        o = apply_to_shadow(c, p, v);
        pending_outcomes.push_back(typed ? want : o);
        cmd_tally[c]++;
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write the capacity register with the block idle.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = cap;
        cfg_writes++;
    endtask

    // Random value: full-range words, a small alphabet so that duplicates show up
    // for find, and the two extremes.
    function automatic logic [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45) return $urandom;
        if (r < 72) return $urandom_range(7);
        if (r < 82) return '1;
        if (r < 88) return '0;
        return $urandom;
    endfunction

    // Build one random command word. Most words are well formed for the current
    // shadow state; the rest use boundary or out-of-range positions.
    task automatic pick_random_word(output cmd_e c, output logic [CNT_W-1:0] p,
                                    output logic [WORD_W-1:0] v);
        int r;
        int rp;
        if (mix_left == 0)
        begin
            r = $urandom_range(99);
            traffic_mix = (r < 40) ? MIX_FILL : (r < 70) ? MIX_DRAIN : MIX_BLEND;
            mix_left    = $urandom_range(20, 80);
        end
        mix_left--;

        r = $urandom_range(99);
        case (traffic_mix)
            MIX_FILL:
                c = (r < 35) ? CMD_PUSH : (r < 65) ? CMD_INSERT : (r < 73) ? CMD_SET :
                    (r < 81) ? CMD_GET : (r < 91) ? CMD_FIND : (r < 95) ? CMD_POP :
                    (r < 99) ? CMD_REMOVE : CMD_CLEAR;
            MIX_DRAIN:
                c = (r < 30) ? CMD_POP : (r < 60) ? CMD_REMOVE : (r < 70) ? CMD_GET :
                    (r < 78) ? CMD_SET : (r < 88) ? CMD_FIND : (r < 93) ? CMD_PUSH :
                    (r < 98) ? CMD_INSERT : CMD_CLEAR;
            default:
            begin
                c = cmd_e'($urandom_range(7));
                // Keep clear rare so the array gets some depth.
                if (c == CMD_CLEAR && r < 70) c = CMD_FIND;
            end
        endcase

        v  = pick_value();
        rp = $urandom_range(99);
        case (c)
            CMD_GET, CMD_SET, CMD_REMOVE:
                if (rp < 85 && shadow_count > 0) p = CNT_W'($urandom_range(shadow_count - 1));
                else if (rp < 92) p = shadow_count[CNT_W-1:0];
                else p = CNT_W'($urandom_range(127));
            CMD_INSERT:
                if (rp < 85) p = CNT_W'($urandom_range(shadow_count));
                else if (rp < 92) p = shadow_count[CNT_W-1:0] + 1'b1;
                else p = CNT_W'($urandom_range(127));
            default:
                p = CNT_W'($urandom_range(127));
        endcase

        // Search for a stored word more often than not.
        if (c == CMD_FIND && shadow_count > 0 && $urandom_range(99) < 60)
            v = shadow_words[$urandom_range(shadow_count - 1)];
    endtask

    task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        error_count++;
    endtask

    // Result side: check each accepted result word against the oldest owed one,
    // then draw ready for the next cycle.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.status      = status_e'(rsp_if.status);
                got.data        = rsp_if.data;
                got.found       = rsp_if.found;
                got.found_index = rsp_if.found_index;
                got.count       = rsp_if.count;
                got.empty_res   = rsp_if.empty_res;
                got.full_res    = rsp_if.full_res;
                results_seen++;
                status_tally[got.status]++;
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result word with nothing owed, got status %0d count %0d",
                             $time, got.status, got.count);
                    error_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status)
                        report_field("status", want.status, got.status);
                    if (got.data !== want.data)
                        report_field("data", want.data, got.data);
                    if (got.found !== want.found)
                        report_field("found", want.found, got.found);
                    if (got.found_index !== want.found_index)
                        report_field("found_index", want.found_index, got.found_index);
                    if (got.count !== want.count)
                        report_field("count", want.count, got.count);
                    if (got.empty_res !== want.empty_res)
                        report_field("empty_res", want.empty_res, got.empty_res);
                    if (got.full_res !== want.full_res)
                        report_field("full_res", want.full_res, got.full_res);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CNT_W-1:0]  cap_plan [N_PHASES];
        cmd_e              c;
        logic [CNT_W-1:0]  p;
        logic [WORD_W-1:0] v;
        int                ph;
        int                n;

        // Drive every input to a known value from time zero.
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= CMD_GET;
        req_if.position  <= '0;
        req_if.value     <= '0;
        recv_stall_pct   <= 0;
        send_idle_pct    = 0;
        error_count      = 0;
        quiet_cycles     = 0;
        results_seen     = 0;
        cfg_writes       = 0;
        mix_left         = 0;
        traffic_mix      = MIX_FILL;
        status_tally     = '{default: 0};
        cmd_tally        = '{default: 0};
        shadow_count     = 0;
        shadow_cap       = CAP_RESET;
        foreach (shadow_words[i]) shadow_words[i] = '0;

        // Capacity per random phase: reset value, then lowered below the count,
        // zero, above the depth, and values in between.
        cap_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd17, 7'd2, 7'd64, 7'd100};

        // Directed table. Reset state: empty array, capacity 64.
        add_typed  (CMD_GET,    7'd0,   32'h0,         STAT_INDEX, 7'd0, 1'b1, 1'b0);
        add_typed  (CMD_POP,    7'd0,   32'h0,         STAT_UNDER, 7'd0, 1'b1, 1'b0);
        add_typed  (CMD_REMOVE, 7'd0,   32'h0,         STAT_INDEX, 7'd0, 1'b1, 1'b0);
        add_typed  (CMD_SET,    7'd0,   32'h1,         STAT_INDEX, 7'd0, 1'b1, 1'b0);
        add_typed  (CMD_FIND,   7'd0,   32'h0,         STAT_OK,    7'd0, 1'b1, 1'b0);
        add_typed  (CMD_INSERT, 7'd1,   32'h5,         STAT_INDEX, 7'd0, 1'b1, 1'b0);
        add_typed  (CMD_INSERT, 7'd0,   32'hFFFF_FFFF, STAT_OK,    7'd1, 1'b0, 1'b0);
        add_typed  (CMD_PUSH,   7'd127, 32'h0,         STAT_OK,    7'd2, 1'b0, 1'b0);
        add_checked(CMD_INSERT, 7'd1,   32'h8000_0001);
        add_checked(CMD_GET,    7'd2,   32'h0);
        add_checked(CMD_FIND,   7'd0,   32'hFFFF_FFFF);
        add_typed  (CMD_SET,    7'd127, 32'h1234_5678, STAT_INDEX, 7'd3, 1'b0, 1'b0);
        add_typed  (CMD_GET,    7'd64,  32'h0,         STAT_INDEX, 7'd3, 1'b0, 1'b0);
        add_checked(CMD_REMOVE, 7'd1,   32'h0);
        add_checked(CMD_PUSH,   7'd0,   32'hFFFF_FFFF);
        add_checked(CMD_SET,    7'd1,   32'h1234_5678);
        add_checked(CMD_FIND,   7'd0,   32'hFFFF_FFFF);
        // Capacity equal to the count: full, then an index fault ranks above no room.
        add_cfg    (7'd3);
        add_typed  (CMD_PUSH,   7'd0,   32'h7,         STAT_OVER,  7'd3, 1'b0, 1'b1);
        add_typed  (CMD_INSERT, 7'd5,   32'h7,         STAT_INDEX, 7'd3, 1'b0, 1'b1);
        add_typed  (CMD_INSERT, 7'd3,   32'h7,         STAT_OVER,  7'd3, 1'b0, 1'b1);
        add_checked(CMD_POP,    7'd0,   32'h0);
        add_typed  (CMD_CLEAR,  7'd0,   32'h0,         STAT_OK,    7'd0, 1'b1, 1'b0);
        // Zero capacity: never any room, always full.
        add_cfg    (7'd0);
        add_typed  (CMD_PUSH,   7'd0,   32'h9,         STAT_OVER,  7'd0, 1'b1, 1'b1);
        // Capacity above the depth saturates to it.
        add_cfg    (7'd127);
        add_typed  (CMD_FIND,   7'd0,   32'h9,         STAT_OK,    7'd0, 1'b1, 1'b0);

        // Hold reset, then release it at an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
                write_capacity(stim_rows[i].value[CNT_W-1:0]);
            else
                send_word(stim_rows[i].cmd, stim_rows[i].position, stim_rows[i].value,
                          stim_rows[i].typed, stim_rows[i].want);
        end

        // Random phases. Each capacity write waits for the array to drain; the
        // idling pattern cycles through none, sender, receiver and both.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            write_capacity(cap_plan[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 79;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct <= 27;
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                pick_random_word(c, p, v);
                send_word(c, p, v, 1'b0, '0);
            end
        end

        // Drain, then let the pipeline settle.
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
            error_count++;
        end

        $display("Ran %0d command words (get %0d set %0d push %0d pop %0d insert %0d remove %0d",
                 results_seen, cmd_tally[CMD_GET], cmd_tally[CMD_SET], cmd_tally[CMD_PUSH],
                 cmd_tally[CMD_POP], cmd_tally[CMD_INSERT], cmd_tally[CMD_REMOVE]);
        $display("  find %0d clear %0d) over %0d capacity writes; ok %0d index %0d over %0d under %0d",
                 cmd_tally[CMD_FIND], cmd_tally[CMD_CLEAR], cfg_writes, status_tally[STAT_OK],
                 status_tally[STAT_INDEX], status_tally[STAT_OVER], status_tally[STAT_UNDER]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
